// File: design/rkc_pkg.sv
`timescale 1ns / 1ps
// shared types, codes and constants of the running key letter cipher
// no dependencies

package rkc_pkg;

  localparam int PAGES_DEF   = 4;
  localparam int KEY_LEN_DEF = 256;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_ENC  = 2'd1;
  localparam logic [1:0] OP_DEC  = 2'd2;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_BADKEY = 2'd1;
  localparam logic [1:0] ST_EMPTY  = 2'd2;
  localparam logic [1:0] ST_FULL   = 2'd3;

  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5a;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7a;
  localparam logic [5:0] ALPHA_LEN  = 6'd26;

  typedef enum logic [1:0] {
    KIND_LOAD,
    KIND_ENC,
    KIND_DEC,
    KIND_NOP
  } kind_e;

  // a classified word as it sits in the queue
  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
    logic       first;
    logic [1:0] page;
    logic       is_space;
    logic       is_letter;
    logic       is_upper;
    logic [4:0] offset;
  } item_t;

endpackage

// File: design/rkc_if.sv
`timescale 1ns / 1ps
// valid/ready channels for input words and result words
// no dependencies

interface rkc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [7:0] data_byte;
  logic       first;
  logic [1:0] load_page;

  modport source (output valid, opcode, data_byte, first, load_page, input ready);
  modport sink   (input valid, opcode, data_byte, first, load_page, output ready);
endinterface

interface rkc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] status;

  modport source (output valid, out_byte, status, input ready);
  modport sink   (input valid, out_byte, status, output ready);
endinterface

// File: design/rkc_front.sv
`timescale 1ns / 1ps
// front end: takes input words and classifies them for the queue
// depends on rkc_pkg and rkc_in_if

module rkc_front (
  rkc_in_if.sink         in_i,
  input  logic           q_full_i,
  output logic           q_push_o,
  output rkc_pkg::item_t q_item_o
);
  import rkc_pkg::*;

  logic is_upper;
  logic is_lower;

  assign in_i.ready = !q_full_i;
  assign q_push_o   = in_i.valid && !q_full_i;

  assign is_upper = (in_i.data_byte >= CH_UPPER_A) && (in_i.data_byte <= CH_UPPER_Z);
  assign is_lower = (in_i.data_byte >= CH_LOWER_A) && (in_i.data_byte <= CH_LOWER_Z);

  always_comb begin
    q_item_o.data      = in_i.data_byte;
    q_item_o.first     = in_i.first;
    q_item_o.page      = in_i.load_page;
    q_item_o.is_space  = (in_i.data_byte == CH_SPACE);
    q_item_o.is_letter = is_upper || is_lower;
    q_item_o.is_upper  = is_upper;
    // letter index from its own case base
    q_item_o.offset    = is_upper ? 5'(in_i.data_byte - CH_UPPER_A)
                                  : 5'(in_i.data_byte - CH_LOWER_A);
    case (in_i.opcode)
      OP_LOAD: q_item_o.kind = KIND_LOAD;
      OP_ENC:  q_item_o.kind = KIND_ENC;
      OP_DEC:  q_item_o.kind = KIND_DEC;
      default: q_item_o.kind = KIND_NOP;
    endcase
  end

endmodule

// File: design/rkc_queue.sv
`timescale 1ns / 1ps
// short queue of classified words between front and back
// depends on rkc_pkg

module rkc_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  rkc_pkg::item_t item_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output rkc_pkg::item_t item_o
);
  import rkc_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  item_t            buf_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;

  assign full_o  = (count_q == CNT_W'(QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign item_o  = buf_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    case ({push_i, pop_i})
      2'b10:   count_d = count_q + CNT_W'(1);
      2'b01:   count_d = count_q - CNT_W'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wr_ptr_q] <= item_i;
    end
  end

`ifndef ASSERT_OFF
  a_fill_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && !pop_i |=> count_q == $past(count_q) + CNT_W'(1))
    else $error("queue count did not follow a lone push");
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> count_q != '0)
    else $error("queue popped while empty");
  a_push_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("queue written while full");
`endif

endmodule

// File: design/rkc_back.sv
`timescale 1ns / 1ps
// back end: key pages, key position and the mod 26 shift, with the result register
// depends on rkc_pkg and rkc_out_if

module rkc_back #(
  parameter int PAGES   = rkc_pkg::PAGES_DEF,
  parameter int KEY_LEN = rkc_pkg::KEY_LEN_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic [1:0]     cfg_wdata_i,
  input  logic           q_empty_i,
  input  rkc_pkg::item_t q_item_i,
  output logic           q_pop_o,
  rkc_out_if.source      out_o
);
  import rkc_pkg::*;

  localparam int PG_W   = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int POS_W  = (KEY_LEN > 1) ? $clog2(KEY_LEN) : 1;
  localparam int LEN_W  = $clog2(KEY_LEN + 1);
  localparam int DEPTH  = PAGES * KEY_LEN;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  item_t             it;
  logic              fire;
  logic [1:0]        sel_q;
  logic [LEN_W-1:0]  len_q [PAGES];
  logic [LEN_W-1:0]  len_d [PAGES];
  logic [POS_W-1:0]  pos_q, pos_d;
  logic              p0_wr_q, p0_wr_d;

  logic              ld_ok, sel_ok;
  logic [PG_W-1:0]   ld_idx, sel_idx;
  logic [LEN_W-1:0]  ld_len, sel_len;
  logic [POS_W-1:0]  pos0, pos_use;
  logic [LEN_W-1:0]  pos_inc;

  logic              we_c, re_c;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [1:0]        status_d;
  logic              xform_d;

  logic [4:0]        mem [DEPTH];
  logic [4:0]        key_q;
  logic              s2_valid_q;
  logic [7:0]        byte_q;
  logic [1:0]        status_q;
  logic              xform_q, enc_q, upper_q, zero_key_q;
  logic [4:0]        off_q;

  logic [4:0]        key;
  logic [5:0]        sum, diff, shifted;
  logic [7:0]        base;

  assign it      = q_item_i;
  assign fire    = !q_empty_i && (!s2_valid_q || out_o.ready);
  assign q_pop_o = fire;

  assign ld_ok   = 32'(it.page) < PAGES;
  assign ld_idx  = PG_W'(it.page);
  assign sel_ok  = 32'(sel_q) < PAGES;
  assign sel_idx = PG_W'(sel_q);
  assign ld_len  = it.first ? '0 : len_q[ld_idx];
  assign sel_len = len_q[sel_idx];
  assign pos0    = it.first ? '0 : pos_q;
  // a position left over from a longer page restarts at zero
  assign pos_use = (LEN_W'(pos0) >= sel_len) ? '0 : pos0;
  assign pos_inc = LEN_W'(pos_use) + LEN_W'(1);

  always_comb begin
    len_d    = len_q;
    pos_d    = pos_q;
    p0_wr_d  = p0_wr_q;
    we_c     = 1'b0;
    re_c     = 1'b0;
    waddr    = ADDR_W'(32'(ld_idx) * KEY_LEN + 32'(ld_len));
    raddr    = ADDR_W'(32'(sel_idx) * KEY_LEN + 32'(pos_use));
    status_d = ST_OK;
    xform_d  = 1'b0;
    case (it.kind)
      KIND_LOAD: begin
        if (!ld_ok) begin
          status_d = ST_FULL;
        end else begin
          len_d[ld_idx] = ld_len;
          if (it.is_space) begin
            status_d = ST_OK;
          end else if (!it.is_letter) begin
            status_d = ST_BADKEY;
          end else if (ld_len >= LEN_W'(KEY_LEN)) begin
            status_d = ST_FULL;
          end else begin
            we_c          = 1'b1;
            len_d[ld_idx] = ld_len + LEN_W'(1);
            if ((ld_idx == '0) && (ld_len == '0)) begin
              p0_wr_d = 1'b1;
            end
          end
        end
      end
      KIND_ENC, KIND_DEC: begin
        pos_d = pos0;
        if (!sel_ok || (sel_len == '0)) begin
          status_d = ST_EMPTY;
        end else if (!it.is_space) begin
          re_c    = 1'b1;
          pos_d   = (pos_inc >= sel_len) ? '0 : POS_W'(pos_inc);
          xform_d = it.is_letter;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q      <= '0;
      pos_q      <= '0;
      p0_wr_q    <= 1'b0;
      s2_valid_q <= 1'b0;
      for (int i = 0; i < PAGES; i++) begin
        len_q[i] <= (i == 0) ? LEN_W'(1) : '0;
      end
    end else begin
      if (cfg_we_i) begin
        sel_q <= cfg_wdata_i;
      end
      if (fire) begin
        len_q      <= len_d;
        pos_q      <= pos_d;
        p0_wr_q    <= p0_wr_d;
        s2_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        s2_valid_q <= 1'b0;
      end
    end
  end

  // result stage payload
  always_ff @(posedge clk_i) begin
    if (fire) begin
      byte_q     <= it.data;
      status_q   <= status_d;
      xform_q    <= xform_d;
      enc_q      <= (it.kind == KIND_ENC);
      upper_q    <= it.is_upper;
      off_q      <= it.offset;
      zero_key_q <= (raddr == '0) && !p0_wr_q;
    end
  end

  // key store: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (fire && we_c) begin
      mem[waddr] <= it.offset;
    end
    if (fire && re_c) begin
      key_q <= mem[raddr];
    end
  end

  assign key     = zero_key_q ? 5'd0 : key_q;
  assign sum     = {1'b0, off_q} + {1'b0, key};
  assign diff    = {1'b0, off_q} - {1'b0, key};
  assign base    = upper_q ? CH_UPPER_A : CH_LOWER_A;
  assign shifted = enc_q ? ((sum >= ALPHA_LEN) ? sum - ALPHA_LEN : sum)
                         : ((off_q < key) ? diff + ALPHA_LEN : diff);

  assign out_o.valid    = s2_valid_q;
  assign out_o.status   = status_q;
  assign out_o.out_byte = xform_q ? base + 8'(shifted) : byte_q;

`ifndef ASSERT_OFF
  a_fire_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> s2_valid_q)
    else $error("result stage empty after a word was taken");
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_valid_q && !out_o.ready |=> $stable(byte_q) && $stable(status_q) && $stable(key_q))
    else $error("result stage changed while stalled");
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> 32'(pos_q) < KEY_LEN)
    else $error("key position beyond page size");
`endif

endmodule

// File: design/running_key_letter_cipher_top.sv
`timescale 1ns / 1ps
// top level of the running key letter cipher
// depends on rkc_pkg, rkc_if, rkc_front, rkc_queue and rkc_back

// Running key cipher over ASCII words. Load words (opcode 0) append key letters to one
// of PAGES pages of up to KEY_LEN letters; spaces are dropped, other non-letters are
// refused with status 1, a letter past the page end gets status 3, and first empties
// the page before the word is taken. Encrypt and decrypt words (opcodes 1 and 2) shift
// a text letter by the current key letter of the page chosen by page_select, mod 26,
// keeping its case; spaces pass and keep the key position, other non-letters pass but
// use up a position, first restarts the position, and an empty page gives status 2.
// After reset page 0 holds the one letter 'a' (shift zero). Rate: one word per clock
// in steady state while the output is ready, set by the key store, which takes one write
// and one read per cycle in the back end; a result passes through the queue and then
// the result register before it is valid. A four entry queue between the classifying
// front end and the back end, plus the result register, lets either side stall alone.
// No clearing pass after reset is needed. The user must write page_select only
// while no word is in flight; the block itself does not enforce it.

module running_key_letter_cipher_top #(
  parameter int PAGES   = rkc_pkg::PAGES_DEF,
  parameter int KEY_LEN = rkc_pkg::KEY_LEN_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_wdata_i,
  rkc_in_if.sink     in_i,
  rkc_out_if.source  out_o
);
  import rkc_pkg::*;

  // queue handshake between the two halves
  logic  q_push;
  logic  q_full;
  logic  q_pop;
  logic  q_empty;
  item_t q_wr_item;
  item_t q_rd_item;

  // front: decode opcode, spot letters and spaces, work out letter index
  rkc_front u_front (
    .in_i     (in_i),
    .q_full_i (q_full),
    .q_push_o (q_push),
    .q_item_o (q_wr_item)
  );

  rkc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (q_wr_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .item_o  (q_rd_item)
  );

  // back: page lengths, key position, key store and result register
  rkc_back #(
    .PAGES   (PAGES),
    .KEY_LEN (KEY_LEN)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .q_empty_i   (q_empty),
    .q_item_i    (q_rd_item),
    .q_pop_o     (q_pop),
    .out_o       (out_o)
  );

endmodule

// File: tb/tb_running_key_letter_cipher_top.sv
`timescale 1ns / 1ps
// self-checking bench for running_key_letter_cipher_top: directed words, then random key
// loads, messages and noise under random idling and back-pressure
// depends on rkc_pkg, rkc_if and the design top level

module tb_running_key_letter_cipher_top;
  import rkc_pkg::*;

  localparam int         PAGES    = PAGES_DEF;
  localparam int         KEY_LEN  = KEY_LEN_DEF;
  localparam logic [1:0] OP_NONE  = 2'd3;    // opcode with no function, echoed
  localparam int         N_RANDOM = 550;
  localparam int         LIMIT    = 300000;  // cycles before the run is declared hung

  typedef struct {
    logic [1:0] op;
    logic [7:0] data;
    logic       first;
    logic [1:0] page;
  } word_t;

  typedef struct {
    logic [7:0] out_byte;
    logic [1:0] status;
  } result_t;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [1:0] cfg_wdata_i;

  rkc_in_if  in_if ();
  rkc_out_if out_if ();

  running_key_letter_cipher_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  // words waiting to be offered, and results still owed by the block
  word_t   tx_words[$];
  result_t due_results[$];

  // shadow copy of the key store and cipher state
  logic [4:0] key_mem [PAGES][KEY_LEN];
  logic [8:0] key_len [PAGES];
  logic [7:0] key_pos;
  logic [1:0] sel_page;

  int   bad_cnt;
  int   cycles;
  int   words_queued;
  logic in_acc;
  bit   tx_idle_en;
  bit   rx_idle_en;
  int   gap_left;
  int   stall_left;
  int   hold_left;
  int   hold_runs;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic bit is_up(logic [7:0] c);
    return c >= CH_UPPER_A && c <= CH_UPPER_Z;
  endfunction

  function automatic bit is_low(logic [7:0] c);
    return c >= CH_LOWER_A && c <= CH_LOWER_Z;
  endfunction

  // most gaps short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  // advance the shadow state by one word and return the result it should give
  function automatic result_t cipher_word(word_t w);
    result_t    r;
    logic [8:0] len;
    int         p;
    int         k;
    int         base;
    r.out_byte = w.data;
    r.status   = ST_OK;
    case (w.op)
      OP_LOAD: begin
        if (w.first) key_len[w.page] = '0;
        if (w.data == CH_SPACE) begin
          r.status = ST_OK;                 // spaces are dropped from the key
        end else if (!is_up(w.data) && !is_low(w.data)) begin
          r.status = ST_BADKEY;
        end else if (key_len[w.page] >= KEY_LEN) begin
          r.status = ST_FULL;
        end else begin
          // key letters count case-insensitively
          k = is_up(w.data) ? w.data - CH_UPPER_A : w.data - CH_LOWER_A;
          key_mem[w.page][key_len[w.page]] = k[4:0];
          key_len[w.page] = key_len[w.page] + 9'd1;
        end
      end
      OP_ENC, OP_DEC: begin
        if (w.first) key_pos = '0;
        len = key_len[sel_page];
        if (len == 0) begin
          r.status = ST_EMPTY;
        end else if (w.data != CH_SPACE) begin
          // a stale position past the page end falls back to the start
          p = (key_pos >= len) ? 0 : key_pos;
          k = key_mem[sel_page][p];
          key_pos = (p + 1 >= len) ? 8'd0 : 8'(p + 1);
          if (is_up(w.data) || is_low(w.data)) begin
            base = is_up(w.data) ? CH_UPPER_A : CH_LOWER_A;
            if (w.op == OP_ENC) r.out_byte = 8'((w.data - base + k) % ALPHA_LEN + base);
            else r.out_byte = 8'((w.data - base + ALPHA_LEN - k) % ALPHA_LEN + base);
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // prediction on acceptance, result checking, and the hang guard
  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    word_t   w;
    in_acc <= in_if.valid && in_if.ready;
    if (rst_ni) begin
      cycles = cycles + 1;
      if (cycles > LIMIT) begin
        $display("%0t: run stalled after %0d cycles", $time, cycles);
        $display("[FAIL] regression broken");
        $finish;
      end else begin
        if (cfg_we_i) sel_page = cfg_wdata_i;
        if (in_if.valid && in_if.ready) begin
          w.op    = in_if.opcode;
          w.data  = in_if.data_byte;
          w.first = in_if.first;
          w.page  = in_if.load_page;
          due_results.insert(due_results.size(), cipher_word(w));
        end
        if (out_if.valid && out_if.ready) begin
          got.out_byte = out_if.out_byte;
          got.status   = out_if.status;
          if (due_results.size() == 0) begin
            $display("%0t: unexpected word, expected none, got byte %h status %0d",
                     $time, got.out_byte, got.status);
            bad_cnt = bad_cnt + 1;
          end else begin
            want = due_results.pop_front();
            if (got.out_byte !== want.out_byte) begin
              $display("%0t: out_byte expected %h got %h", $time, want.out_byte, got.out_byte);
              bad_cnt = bad_cnt + 1;
            end
            if (got.status !== want.status) begin
              $display("%0t: status expected %0d got %0d", $time, want.status, got.status);
              bad_cnt = bad_cnt + 1;
            end
          end
        end
      end
    end
  end

  // sender: holds a word until taken, then maybe idles before the next
  always @(negedge clk_i) begin
    word_t w;
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || in_acc) begin
      if (gap_left > 0) begin
        gap_left = gap_left - 1;
        in_if.valid <= 1'b0;
      end else if (tx_words.size() > 0) begin
        w = tx_words.pop_front();
        in_if.opcode    <= w.op;
        in_if.data_byte <= w.data;
        in_if.first     <= w.first;
        in_if.load_page <= w.page;
        in_if.valid     <= 1'b1;
        gap_left = tx_idle_en ? pick_gap() : 0;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // receiver: random stalls, plus a long hold-off while the sender has plenty queued
  always @(negedge clk_i) begin
    logic rdy;
    rdy = 1'b1;
    if (!rst_ni) begin
      rdy = 1'b0;
    end else begin
      if (hold_runs < 2 && hold_left == 0 && tx_words.size() > 24) begin
        hold_left = 80;
        hold_runs = hold_runs + 1;
      end
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        rdy = 1'b0;
      end else if (stall_left > 0) begin
        stall_left = stall_left - 1;
        rdy = 1'b0;
      end else if (rx_idle_en && $urandom_range(0, 3) == 0) begin
        stall_left = pick_gap();
      end
    end
    out_if.ready <= rdy;
  end

  task automatic put_word(logic [1:0] op, logic [7:0] data, logic first, logic [1:0] page);
    word_t w;
    w.op    = op;
    w.data  = data;
    w.first = first;
    w.page  = page;
    tx_words.insert(tx_words.size(), w);
    words_queued = words_queued + 1;
  endtask

  function automatic logic [7:0] any_letter();
    logic [7:0] c;
    c = 8'($urandom_range(0, 25));
    return $urandom_range(0, 1) ? c + CH_UPPER_A : c + CH_LOWER_A;
  endfunction

  // a key page load: mostly letters, some spaces, a few junk bytes
  task automatic put_key_run(logic [1:0] page, int n, bit restart, int junk_pct);
    int         i;
    int         r;
    logic [7:0] c;
    for (i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < junk_pct) c = 8'($urandom_range(0, 255));
      else if (r < junk_pct + 10) c = CH_SPACE;
      else c = any_letter();
      put_word(OP_LOAD, c, restart && i == 0, page);
    end
  endtask

  // a message of text words, occasionally restarting the key mid-stream
  task automatic put_message(logic [1:0] op, int n, bit restart);
    int         i;
    int         r;
    logic [7:0] c;
    for (i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 65) c = any_letter();
      else if (r < 80) c = CH_SPACE;
      else c = 8'($urandom_range(0, 255));
      put_word(op, c, (restart && i == 0) || $urandom_range(0, 19) == 0, 2'($urandom_range(0, 3)));
    end
  endtask

  // wait for every word to be taken and answered, let the pipe settle, then write
  task automatic set_page(logic [1:0] sel);
    @(negedge clk_i);
    while (tx_words.size() > 0 || in_if.valid || due_results.size() > 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = sel;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
  endtask

  initial begin
    int   i;
    int   n;
    int   seg;
    int   phase;
    logic [1:0] op;
    clk_i       = 1'b0;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    in_if.valid     = 1'b0;
    in_if.opcode    = OP_LOAD;
    in_if.data_byte = '0;
    in_if.first     = 1'b0;
    in_if.load_page = '0;
    out_if.ready    = 1'b0;
    in_acc      = 1'b0;
    bad_cnt     = 0;
    cycles      = 0;
    words_queued = 0;
    gap_left    = 0;
    stall_left  = 0;
    hold_left   = 0;
    hold_runs   = 0;
    tx_idle_en  = 1'b1;
    rx_idle_en  = 1'b1;
    // shadow state as after reset: page 0 is the single letter a
    for (i = 0; i < PAGES; i++) key_len[i] = '0;
    key_len[0]    = 9'd1;
    key_mem[0][0] = '0;
    key_pos       = '0;
    sel_page      = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: reset page passes letters unchanged, text corner bytes, opcode 3
    put_word(OP_ENC, CH_LOWER_A, 1'b1, 2'd0);
    put_word(OP_ENC, CH_LOWER_Z, 1'b0, 2'd3);
    put_word(OP_DEC, CH_UPPER_A, 1'b0, 2'd0);
    put_word(OP_DEC, CH_UPPER_Z, 1'b0, 2'd0);
    put_word(OP_ENC, 8'h21, 1'b0, 2'd0);
    put_word(OP_ENC, CH_SPACE, 1'b0, 2'd0);
    put_word(OP_NONE, 8'hff, 1'b1, 2'd3);
    // key bytes: uppercase, lowercase, space, and junk, some just beside the letter ranges
    put_word(OP_LOAD, CH_UPPER_Z, 1'b1, 2'd1);
    put_word(OP_LOAD, 8'h62, 1'b0, 2'd1);
    put_word(OP_LOAD, CH_SPACE, 1'b0, 2'd1);
    put_word(OP_LOAD, 8'h7b, 1'b0, 2'd1);
    put_word(OP_LOAD, 8'h00, 1'b0, 2'd1);
    put_word(OP_LOAD, 8'hff, 1'b0, 2'd1);
    put_word(OP_LOAD, 8'h60, 1'b0, 2'd1);
    put_word(OP_LOAD, 8'h40, 1'b0, 2'd1);
    // a rejected byte with first set still empties the page
    put_word(OP_LOAD, 8'h5b, 1'b1, 2'd2);
    set_page(2'd1);
    put_word(OP_ENC, CH_LOWER_Z, 1'b1, 2'd0);
    put_word(OP_DEC, 8'h42, 1'b0, 2'd0);
    put_word(OP_ENC, CH_SPACE, 1'b0, 2'd0);
    put_word(OP_ENC, 8'h31, 1'b0, 2'd0);
    put_word(OP_ENC, 8'h59, 1'b0, 2'd0);
    // empty selected page, with and without a restart
    set_page(2'd2);
    put_word(OP_ENC, 8'h71, 1'b0, 2'd0);
    put_word(OP_DEC, 8'h71, 1'b1, 2'd0);

    phase = 0;
    while (words_queued < N_RANDOM - 40) begin
      tx_idle_en = $urandom_range(0, 3) != 0;
      rx_idle_en = $urandom_range(0, 3) != 0;
      if (phase == 1) begin
        // overfill page 3 and then run a long message through it; a long receiver
        // hold-off can land here since the sender has hundreds of words waiting
        set_page(2'd3);
        put_key_run(2'd3, KEY_LEN + 6, 1'b1, 2);
        put_message(OP_ENC, 20, 1'b1);
        put_message(OP_DEC, 20, 1'b0);
      end else begin
        set_page(2'($urandom_range(0, 3)));
        for (seg = $urandom_range(3, 6); seg > 0; seg--) begin
          n = $urandom_range(0, 99);
          if (n < 40) begin
            put_key_run(2'($urandom_range(0, 3)), $urandom_range(1, 12),
                        $urandom_range(0, 4) != 0, 10);
          end else if (n < 85) begin
            op = $urandom_range(0, 1) ? OP_ENC : OP_DEC;
            put_message(op, $urandom_range(1, 30), $urandom_range(0, 6) != 0);
          end else begin
            for (i = $urandom_range(1, 5); i > 0; i--) begin
              put_word(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                       1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)));
            end
          end
        end
      end
      phase = phase + 1;
    end
    set_page(2'd0);
    put_message(OP_ENC, 10, 1'b1);

    // drain, then give the last result time to show up if anything is left over
    @(negedge clk_i);
    while (tx_words.size() > 0 || in_if.valid || due_results.size() > 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
    if (bad_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
